// File: hdl/awt_pkg.sv
package awt_pkg;

  localparam int CELL_BITS = 32;
  localparam int ADDR_W = 64;
  localparam int ENTRY_IDX_W = 4;
  localparam int ENTRIES_IN_USE_W = 5;
  localparam int PARENT_CELLS_W = 2;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_INDEX_W = 1;

  localparam int WINDOW_ENTRIES_DEFAULT = 16;
  localparam int ADDRESS_CELLS_DEFAULT = 2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TRANSLATE = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_NO_WINDOW = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;
  localparam logic [1:0] STATUS_WRAPS = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] CFG_ENTRIES_IN_USE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PARENT_CELLS = 1'd1;

  typedef struct packed {
    logic [ADDR_W-1:0] child_base;
    logic [ADDR_W-1:0] parent_base;
    logic [ADDR_W-1:0] window_size;
  } win_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK
  } state_t;

endpackage

// File: hdl/awt_window_ram.sv
module awt_window_ram #(
  parameter int DEPTH = awt_pkg::WINDOW_ENTRIES_DEFAULT,
  parameter int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IW-1:0]       wr_addr,
  input  awt_pkg::win_entry_t wr_data,
  input  logic                rd_en,
  input  logic [IW-1:0]       rd_addr,
  output awt_pkg::win_entry_t rd_data
);
  import awt_pkg::*;

  win_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/address_window_translate_core.sv
// write item: result registered in the cycle after accept, busy stays low, one write per cycle while idle
// translate item: entries read one per cycle from the window ram, two compare
// stages then one overflow check stage; a scan stops at the first hit, and a
// miss is reported once all entries in use have been compared
// busy is high until the result cycle; rst (synchronous) resets config and control
// the receiver cannot stall, each result is shown for one cycle with done
module address_window_translate_core #(
  parameter int WINDOW_ENTRIES = awt_pkg::WINDOW_ENTRIES_DEFAULT,
  parameter int ADDRESS_CELLS = awt_pkg::ADDRESS_CELLS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 command,
  input  logic [awt_pkg::ENTRY_IDX_W-1:0]      entry_index,
  input  logic [awt_pkg::ADDR_W-1:0]           child_base,
  input  logic [awt_pkg::ADDR_W-1:0]           parent_base,
  input  logic [awt_pkg::ADDR_W-1:0]           window_size,
  input  logic [awt_pkg::ADDR_W-1:0]           address,
  input  logic                                 cfg_we,
  input  logic [awt_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [awt_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                 done,
  output logic [1:0]                           status,
  output logic [awt_pkg::ADDR_W-1:0]           translated_address,
  output logic [awt_pkg::ADDR_W-1:0]           remaining_size,
  output logic [awt_pkg::ENTRY_IDX_W-1:0]      matched_entry
);
  import awt_pkg::*;

  localparam int IW = (WINDOW_ENTRIES > 1) ? $clog2(WINDOW_ENTRIES) : 1;
  localparam int CW = $clog2(WINDOW_ENTRIES + 1);
  localparam logic [ADDR_W-1:0] CMASK =
    (ADDRESS_CELLS >= 2) ? {ADDR_W{1'b1}} : {{(ADDR_W-CELL_BITS){1'b0}}, {CELL_BITS{1'b1}}};
  localparam logic [CW+ENTRIES_IN_USE_W-1:0] ENTRIES_EXT =
    (CW+ENTRIES_IN_USE_W)'(WINDOW_ENTRIES);

  // configuration
  logic [ENTRIES_IN_USE_W-1:0] entries_in_use;
  logic [PARENT_CELLS_W-1:0]   parent_cells;

  // control
  state_t        state;
  state_t        state_next;
  logic          accept;
  logic [CW-1:0] issue_cnt;
  logic [CW-1:0] n_lim;
  logic          wide_q;
  logic          rd_en;
  logic          rd_valid;
  logic          s1_valid;
  logic          scan_hit;
  logic          scan_miss;

  // payload
  logic [ADDR_W-1:0] addr_q;
  logic [IW-1:0]     rd_idx;
  logic [IW-1:0]     s1_idx;
  logic              s1_borrow;
  logic [ADDR_W-1:0] s1_off;
  logic [ADDR_W-1:0] s1_sz;
  logic [ADDR_W-1:0] s1_pb;
  logic [IW-1:0]     hit_idx;
  logic [ADDR_W-1:0] hit_off;
  logic [ADDR_W-1:0] hit_sz;
  logic [ADDR_W-1:0] hit_pb;

  // ram side
  logic                          wr_en;
  logic [IW+ENTRY_IDX_W-1:0]     widx_ext;
  logic [IW-1:0]                 wr_addr;
  win_entry_t                    wr_data;
  win_entry_t                    rd_data;
  logic [ADDR_W:0]               diff;

  // limit and check stage
  logic [CW+ENTRIES_IN_USE_W-1:0] eiu_ext;
  logic [CW+ENTRIES_IN_USE_W-1:0] n_ext;
  logic [ADDR_W-1:0]              pb_m;
  logic [ADDR_W:0]                sum_t;
  logic [ADDR_W:0]                sum_w;
  logic                           ovf_t;
  logic                           ovf_w;
  logic [IW+ENTRY_IDX_W-1:0]      hit_idx_ext;

  assign accept = start && !busy;
  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
      parent_cells <= PARENT_CELLS_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENTRIES_IN_USE: entries_in_use <= cfg_data[ENTRIES_IN_USE_W-1:0];
        CFG_PARENT_CELLS: parent_cells <= cfg_data[PARENT_CELLS_W-1:0];
        default: ;
      endcase
    end
  end

  // window writes
  assign widx_ext = {IW'(0), entry_index};
  assign wr_addr = widx_ext[IW-1:0];
  assign wr_en = accept && (command == CMD_WRITE) && (32'(entry_index) < WINDOW_ENTRIES);
  assign wr_data.child_base = child_base & CMASK;
  assign wr_data.parent_base = parent_base;
  assign wr_data.window_size = window_size & CMASK;

  awt_window_ram #(
    .DEPTH (WINDOW_ENTRIES),
    .IW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (issue_cnt[IW-1:0]),
    .rd_data (rd_data)
  );

  // entries searched, saturated at the table depth
  assign eiu_ext = {CW'(0), entries_in_use};
  assign n_ext = (eiu_ext > ENTRIES_EXT) ? ENTRIES_EXT : eiu_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en = 1'b0;
    scan_hit = 1'b0;
    scan_miss = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && (command == CMD_TRANSLATE)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en = (issue_cnt < n_lim);
        if (s1_valid && !s1_borrow && (s1_off < s1_sz)) begin
          scan_hit = 1'b1;
          state_next = ST_CHECK;
        end else if ((issue_cnt == n_lim) && !rd_valid && !s1_valid) begin
          scan_miss = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_CHECK: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_cnt <= '0;
      rd_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else if (accept) begin
      issue_cnt <= '0;
      rd_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else if ((state == ST_SCAN) && !scan_hit) begin
      rd_valid <= rd_en;
      s1_valid <= rd_valid;
      if (rd_en) begin
        issue_cnt <= issue_cnt + CW'(1);
      end
    end else begin
      rd_valid <= 1'b0;
      s1_valid <= 1'b0;
    end
  end

  // item context
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_q <= address & CMASK;
      n_lim <= n_ext[CW-1:0];
      wide_q <= (parent_cells >= PARENT_CELLS_W'(2));
    end
  end

  // compare pipeline
  assign diff = {1'b0, addr_q} - {1'b0, rd_data.child_base};

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx <= issue_cnt[IW-1:0];
    end
    s1_idx <= rd_idx;
    s1_borrow <= diff[ADDR_W];
    s1_off <= diff[ADDR_W-1:0];
    s1_sz <= rd_data.window_size;
    s1_pb <= rd_data.parent_base;
    if (scan_hit) begin
      hit_idx <= s1_idx;
      hit_off <= s1_off;
      hit_sz <= s1_sz;
      hit_pb <= s1_pb;
    end
  end

  // parent width checks
  assign pb_m = wide_q ? hit_pb : {{(ADDR_W-CELL_BITS){1'b0}}, hit_pb[CELL_BITS-1:0]};
  assign sum_t = {1'b0, hit_off} + {1'b0, pb_m};
  assign sum_w = {1'b0, pb_m} + {1'b0, hit_sz};
  assign ovf_t = sum_t[ADDR_W] || (!wide_q && (sum_t[ADDR_W-1:CELL_BITS] != '0));
  assign ovf_w = sum_w[ADDR_W] || (!wide_q && (sum_w[ADDR_W-1:CELL_BITS] != '0));
  assign hit_idx_ext = {ENTRY_IDX_W'(0), hit_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && (command == CMD_WRITE)) || scan_miss || (state == ST_CHECK);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (command == CMD_WRITE)) begin
      status <= STATUS_OK;
      translated_address <= '0;
      remaining_size <= '0;
      matched_entry <= entry_index;
    end else if (scan_miss) begin
      status <= STATUS_NO_WINDOW;
      translated_address <= '0;
      remaining_size <= '0;
      matched_entry <= '0;
    end else if (state == ST_CHECK) begin
      matched_entry <= hit_idx_ext[ENTRY_IDX_W-1:0];
      if (ovf_t) begin
        status <= STATUS_OVERFLOW;
        translated_address <= '0;
        remaining_size <= '0;
      end else if (ovf_w) begin
        status <= STATUS_WRAPS;
        translated_address <= '0;
        remaining_size <= '0;
      end else begin
        status <= STATUS_OK;
        translated_address <= sum_t[ADDR_W-1:0];
        remaining_size <= hit_sz - hit_off;
      end
    end
  end

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(accept) && ($past(command) == CMD_WRITE)) ||
             ($past(state) == ST_SCAN) || ($past(state) == ST_CHECK))
    else $error("result without a cause");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != STATUS_OK)) |-> (translated_address == '0) && (remaining_size == '0))
    else $error("error result carries an address");

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (issue_cnt <= n_lim))
    else $error("read beyond entries in use");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!rd_valid && !s1_valid))
    else $error("compare pipeline busy while idle");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |=> (state == ST_IDLE) && done)
    else $error("check stage did not complete");

endmodule
